@@ sv/wbmp_pkg.sv @@
// shared types and constants for the wbmp type 0 stream parser
package wbmp_pkg;

  // largest dimension is 2**DIM_BITS - 1
  localparam int DIM_BITS   = 16;
  // longest multibyte integer in bytes
  localparam int MAX_GROUPS = 5;

  // accumulator wide enough for every group and one bit above the dimension
  localparam int ACC_W  = (7 * MAX_GROUPS > DIM_BITS) ? 7 * MAX_GROUPS : DIM_BITS + 1;
  localparam int CNT_W  = $clog2(MAX_GROUPS + 1);
  localparam int PROD_W = 2 * DIM_BITS;
  localparam int LEN_W  = PROD_W - 3;

  // fixed widths of the item fields
  localparam int BYTE_W    = 8;
  localparam int OUT_DIM_W = 16;
  localparam int ERR_W     = 3;
  localparam int KIND_W    = 2;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [2:0] {
    PH_HDR0   = 3'd0,
    PH_HDR1   = 3'd1,
    PH_WIDTH  = 3'd2,
    PH_HEIGHT = 3'd3,
    PH_DATA   = 3'd4,
    PH_DONE   = 3'd5,
    PH_ERROR  = 3'd6
  } phase_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_HDR  = 2'd0,
    KIND_DATA = 2'd1,
    KIND_ERR  = 2'd2,
    KIND_IGN  = 2'd3
  } kind_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE      = 3'd0,
    ERR_HEADER    = 3'd1,
    ERR_TOO_LONG  = 3'd2,
    ERR_TOO_LARGE = 3'd3,
    ERR_TRUNCATED = 3'd4
  } err_e;

  // one input item
  typedef struct packed {
    logic [BYTE_W-1:0] byte_in;
    logic              start_of_file;
    logic              end_of_file;
  } in_item_t;

  // one result item
  typedef struct packed {
    kind_e                kind;
    logic [BYTE_W-1:0]    data_byte;
    logic                 last_data;
    logic [OUT_DIM_W-1:0] image_width;
    logic [OUT_DIM_W-1:0] image_height;
    logic                 dims_ready;
    err_e                 error_code;
  } res_item_t;

endpackage

@@ sv/wbmp_stream_parser.sv @@
// top level of the wbmp type 0 stream parser
// Takes one file byte per item and gives exactly one result item per byte, at up to one
// item per clock: the whole decode of a byte sits between the parse state registers and
// the result register, so a result appears in the cycle after its byte is accepted and a new
// byte is accepted in every cycle in which the result register is empty or being drained.
// The two zero header bytes and the width and height integers give kind 0, image bytes
// kind 1 with tlast on the final one, errors kind 2 with a code, and anything after the
// image or an error kind 3 until a byte with start of file set restarts the parse.
module wbmp_stream_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // byte_in
  input  logic [0:0]  s_axis_tuser,   // start_of_file
  input  logic        s_axis_tlast,   // end_of_file
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // data_byte[7:0], image_width[23:8], image_height[39:24], dims_ready[40],
  // error_code[43:41], zero fill[47:44]
  output logic [47:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast    // last_data
);
  import wbmp_pkg::*;

  in_item_t  in_item;
  res_item_t step_res, out_item;
  logic      take, room;

  assign take                  = s_axis_tvalid && room;
  assign s_axis_tready         = room;
  assign in_item.byte_in       = s_axis_tdata;
  assign in_item.start_of_file = s_axis_tuser[0];
  assign in_item.end_of_file   = s_axis_tlast;

  // per-byte decode
  wbmp_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .item_i (in_item),
    .res_o  (step_res)
  );

  // result register
  wbmp_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (take),
    .item_i  (step_res),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .item_o  (out_item)
  );

  // pack the result fields
  assign m_axis_tdata = {4'b0000, out_item.error_code, out_item.dims_ready,
                         out_item.image_height, out_item.image_width,
                         out_item.data_byte};
  assign m_axis_tuser = out_item.kind;
  assign m_axis_tlast = out_item.last_data;

endmodule

@@ sv/wbmp_parse.sv @@
// parse state and per-byte decode of the header, dimensions and image data
module wbmp_parse (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  wbmp_pkg::in_item_t  item_i,
  output wbmp_pkg::res_item_t res_o
);
  import wbmp_pkg::*;

  phase_e              phase_q, phase_d, base_phase, step_phase;
  logic [ACC_W-1:0]    acc_q, acc_d, base_acc, acc_shift;
  logic [CNT_W-1:0]    cnt_q, cnt_d, base_cnt, cnt_inc;
  logic [DIM_BITS-1:0] width_q, width_d, base_width;
  logic [DIM_BITS-1:0] height_q, height_d, base_height;
  logic [LEN_W-1:0]    left_q, left_d, base_left, left_dec, len_calc;
  logic                dims_q, dims_d, base_dims;
  logic [PROD_W-1:0]   product;
  logic [PROD_W:0]     prod_round;
  logic                more, over_long, too_large, int_done;
  err_e                step_err, err;
  logic [BYTE_W-1:0]   b;
  logic [31:0]         width_ext, height_ext;

  assign b = item_i.byte_in;

  // start of file clears the parse before the byte is used
  always_comb begin
    base_phase  = item_i.start_of_file ? PH_HDR0 : phase_q;
    base_acc    = item_i.start_of_file ? '0 : acc_q;
    base_cnt    = item_i.start_of_file ? '0 : cnt_q;
    base_width  = item_i.start_of_file ? '0 : width_q;
    base_height = item_i.start_of_file ? '0 : height_q;
    base_left   = item_i.start_of_file ? '0 : left_q;
    base_dims   = item_i.start_of_file ? 1'b0 : dims_q;
  end

  // multibyte integer group decode
  assign acc_shift = {base_acc[ACC_W-8:0], b[6:0]};
  assign cnt_inc   = base_cnt + CNT_W'(1);
  assign more      = b[7];
  assign over_long = more && (cnt_inc >= CNT_W'(MAX_GROUPS));
  assign too_large = !more && (acc_shift[ACC_W-1:DIM_BITS] != '0);
  assign int_done  = !more && !too_large;

  // data length, rounded up to whole bytes
  assign product    = PROD_W'(base_width) * PROD_W'(acc_shift[DIM_BITS-1:0]);
  assign prod_round = {1'b0, product} + (PROD_W+1)'(7);
  assign len_calc   = prod_round[PROD_W-1:3];
  assign left_dec   = base_left - LEN_W'(1);

  // error from the byte itself
  always_comb begin
    step_err = ERR_NONE;
    unique case (base_phase)
      PH_HDR0, PH_HDR1: begin
        if (b != '0) step_err = ERR_HEADER;
      end
      PH_WIDTH, PH_HEIGHT: begin
        if (over_long)      step_err = ERR_TOO_LONG;
        else if (too_large) step_err = ERR_TOO_LARGE;
      end
      default: step_err = ERR_NONE;
    endcase
  end

  // phase reached when the byte is fine
  always_comb begin
    step_phase = base_phase;
    unique case (base_phase)
      PH_HDR0:   step_phase = PH_HDR1;
      PH_HDR1:   step_phase = PH_WIDTH;
      PH_WIDTH:  step_phase = int_done ? PH_HEIGHT : PH_WIDTH;
      PH_HEIGHT: step_phase = !int_done ? PH_HEIGHT :
                              (len_calc == '0) ? PH_DONE : PH_DATA;
      PH_DATA:   step_phase = (left_dec == '0) ? PH_DONE : PH_DATA;
      default:   step_phase = base_phase;
    endcase
  end

  // truncation check and final error
  always_comb begin
    err = step_err;
    if (step_err == ERR_NONE && item_i.end_of_file &&
        step_phase != PH_DONE && step_phase != PH_ERROR) begin
      err = ERR_TRUNCATED;
    end
  end

  // next phase
  always_comb begin
    phase_d = (err != ERR_NONE) ? PH_ERROR : step_phase;
  end

  // next datapath state
  always_comb begin
    acc_d    = base_acc;
    cnt_d    = base_cnt;
    width_d  = base_width;
    height_d = base_height;
    left_d   = base_left;
    dims_d   = base_dims;
    unique case (base_phase)
      PH_WIDTH, PH_HEIGHT: begin
        acc_d = acc_shift;
        cnt_d = cnt_inc;
        if (step_err == ERR_NONE && int_done) begin
          if (base_phase == PH_WIDTH) begin
            width_d = acc_shift[DIM_BITS-1:0];
          end else begin
            height_d = acc_shift[DIM_BITS-1:0];
            dims_d   = 1'b1;
            left_d   = len_calc;
          end
          acc_d = '0;
          cnt_d = '0;
        end
      end
      PH_DATA: left_d = left_dec;
      default: ;
    endcase
  end

  // result item
  assign width_ext  = 32'(width_d);
  assign height_ext = 32'(height_d);

  always_comb begin
    res_o.kind         = KIND_IGN;
    res_o.data_byte    = '0;
    res_o.last_data    = 1'b0;
    res_o.image_width  = width_ext[OUT_DIM_W-1:0];
    res_o.image_height = height_ext[OUT_DIM_W-1:0];
    res_o.dims_ready   = dims_d;
    res_o.error_code   = err;
    if (err != ERR_NONE) begin
      res_o.kind = KIND_ERR;
    end else begin
      unique case (base_phase)
        PH_HDR0, PH_HDR1, PH_WIDTH, PH_HEIGHT: res_o.kind = KIND_HDR;
        PH_DATA: begin
          res_o.kind      = KIND_DATA;
          res_o.data_byte = b;
          res_o.last_data = (left_dec == '0);
        end
        default: res_o.kind = KIND_IGN;
      endcase
    end
  end

  // state registers, updated once per accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR0;
      acc_q    <= '0;
      cnt_q    <= '0;
      width_q  <= '0;
      height_q <= '0;
      left_q   <= '0;
      dims_q   <= 1'b0;
    end else if (take_i) begin
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      cnt_q    <= cnt_d;
      width_q  <= width_d;
      height_q <= height_d;
      left_q   <= left_d;
      dims_q   <= dims_d;
    end
  end

endmodule

@@ sv/wbmp_out_reg.sv @@
// result register on the master side, refilled in the cycle it drains
module wbmp_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  wbmp_pkg::res_item_t item_i,
  output logic                room_o,
  output logic                valid_o,
  input  logic                ready_i,
  output wbmp_pkg::res_item_t item_o
);
  import wbmp_pkg::*;

  logic      valid_q, valid_d;
  res_item_t item_q;

  // free when empty or when the held item leaves this cycle
  assign room_o  = !valid_q || ready_i;
  assign valid_d = push_i || (valid_q && !ready_i);

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule
